/* hw/rtl/nearest_scale_fit_address_gen_assert.svh */
// Assertion macros for the fit address generator.
`ifndef NEAREST_SCALE_FIT_ADDRESS_GEN_ASSERT_SVH
`define NEAREST_SCALE_FIT_ADDRESS_GEN_ASSERT_SVH

`define NSF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsf check failed");

`define NSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsf check failed");

`endif

/* hw/rtl/nsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package nsf_pkg;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISP_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISP_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_PITCH   = 3'd4;

   localparam int MAX_DIM = 4096;
   localparam int QUOT_W  = 12;
   localparam int CELLS   = QUOT_W;

   typedef enum logic [2:0] {
      FIT_LOAD, FIT_MUL, FIT_SEL, FIT_DIV, FIT_FIN, FIT_OFS, FIT_IDLE
   } nsf_fit_state_type;

   typedef struct packed {
      logic        ready;
      logic [12:0] sw;
      logic [12:0] sh;
      logic [12:0] fw;
      logic [12:0] fh;
      logic [11:0] hx;
      logic [11:0] hy;
      logic [13:0] pitch;
   } nsf_fit_type;

   typedef struct packed {
      logic        valid;
      logic        in_range;
      logic [12:0] rem_x;
      logic [11:0] dq_x;
      logic [12:0] rem_y;
      logic [11:0] dq_y;
      logic [11:0] disp_x;
      logic [11:0] disp_y;
      logic [24:0] fb_offset;
   } nsf_stage_type;
endpackage
`default_nettype wire

/* hw/rtl/nsf_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface nsf_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] out_x;
   logic [11:0] out_y;
   modport source (output valid, output out_x, output out_y, input ready);
   modport sink (input valid, input out_x, input out_y, output ready);
endinterface
`default_nettype wire

/* hw/rtl/nsf_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface nsf_rsp_if;
   logic        valid;
   logic        ready;
   logic        in_range;
   logic [11:0] src_x;
   logic [11:0] src_y;
   logic [11:0] disp_x;
   logic [11:0] disp_y;
   logic [24:0] fb_offset;
   logic [12:0] fit_width;
   logic [12:0] fit_height;
   modport source (output valid, output in_range, output src_x, output src_y,
      output disp_x, output disp_y, output fb_offset, output fit_width,
      output fit_height, input ready);
   modport sink (input valid, input in_range, input src_x, input src_y,
      input disp_x, input disp_y, input fb_offset, input fit_width,
      input fit_height, output ready);
endinterface
`default_nettype wire

/* hw/rtl/nsf_fit.sv */
`timescale 1ns / 1ps
`default_nettype none
module nsf_fit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [nsf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [nsf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output nsf_pkg::nsf_fit_type                  fit
);
   import nsf_pkg::*;

   localparam int CMP_W = $clog2(MAX_DIM + 1) + 14;

   function automatic logic [12:0] sat_dim(input logic [12:0] v);
      logic [12:0] r;
      r = v;
      if (v == 13'd0) r = 13'd1;
      else if (CMP_W'(v) > CMP_W'(MAX_DIM)) r = 13'(MAX_DIM);
      return r;
   endfunction

   nsf_fit_state_type state_ff, state_in;
   logic [12:0] src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [12:0] dsp_w_ff, dsp_w_in, dsp_h_ff, dsp_h_in;
   logic [13:0] pitch_ff, pitch_in;
   logic [12:0] sw_ff, sw_in, sh_ff, sh_in, dw_ff, dw_in, dh_ff, dh_in;
   logic [25:0] p1_ff, p1_in, p2_ff, p2_in;
   logic        wide_ff, wide_in;
   logic [12:0] div_ff, div_in;
   logic [12:0] rem_ff, rem_in;
   logic [11:0] dq_ff, dq_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [12:0] fw_ff, fw_in, fh_ff, fh_in;
   logic [11:0] hx_ff, hx_in, hy_ff, hy_in;
   logic [13:0] rem_sh;
   logic [12:0] q13;
   logic        down;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIT_LOAD;
         src_w_ff <= 13'd1;
         src_h_ff <= 13'd1;
         dsp_w_ff <= 13'd1;
         dsp_h_ff <= 13'd1;
         pitch_ff <= 14'd1;
      end else begin
         state_ff <= state_in;
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         dsp_w_ff <= dsp_w_in;
         dsp_h_ff <= dsp_h_in;
         pitch_ff <= pitch_in;
      end
      sw_ff   <= sw_in;
      sh_ff   <= sh_in;
      dw_ff   <= dw_in;
      dh_ff   <= dh_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      wide_ff <= wide_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      cnt_ff  <= cnt_in;
      fw_ff   <= fw_in;
      fh_ff   <= fh_in;
      hx_ff   <= hx_in;
      hy_ff   <= hy_in;
   end

   always_comb begin
      state_in = state_ff;
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dsp_w_in = dsp_w_ff;
      dsp_h_in = dsp_h_ff;
      pitch_in = pitch_ff;
      sw_in    = sw_ff;
      sh_in    = sh_ff;
      dw_in    = dw_ff;
      dh_in    = dh_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      wide_in  = wide_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      cnt_in   = cnt_ff;
      fw_in    = fw_ff;
      fh_in    = fh_ff;
      hx_in    = hx_ff;
      hy_in    = hy_ff;
      rem_sh   = {rem_ff, dq_ff[11]};
      q13      = (dq_ff == 12'd0) ? 13'd1 : {1'b0, dq_ff};
      down     = (sw_ff > dw_ff) || (sh_ff > dh_ff);

      case (state_ff)
         FIT_LOAD: begin
            sw_in    = sat_dim(src_w_ff);
            sh_in    = sat_dim(src_h_ff);
            dw_in    = sat_dim(dsp_w_ff);
            dh_in    = sat_dim(dsp_h_ff);
            state_in = FIT_MUL;
         end
         FIT_MUL: begin
            p1_in    = {13'd0, sw_ff} * {13'd0, dh_ff};
            p2_in    = {13'd0, sh_ff} * {13'd0, dw_ff};
            state_in = FIT_SEL;
         end
         FIT_SEL: begin
            wide_in  = p1_ff > p2_ff;
            div_in   = (p1_ff > p2_ff) ? sw_ff : sh_ff;
            rem_in   = (p1_ff > p2_ff) ? p2_ff[24:12] : p1_ff[24:12];
            dq_in    = (p1_ff > p2_ff) ? p2_ff[11:0] : p1_ff[11:0];
            cnt_in   = 4'd0;
            state_in = FIT_DIV;
         end
         FIT_DIV: begin
            if (rem_sh >= {1'b0, div_ff}) begin
               rem_in = 13'(rem_sh - {1'b0, div_ff});
               dq_in  = {dq_ff[10:0], 1'b1};
            end else begin
               rem_in = rem_sh[12:0];
               dq_in  = {dq_ff[10:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(QUOT_W - 1)) state_in = FIT_FIN;
         end
         FIT_FIN: begin
            if (!down) begin
               fw_in = sw_ff;
               fh_in = sh_ff;
            end else if (wide_ff) begin
               fw_in = dw_ff;
               fh_in = q13;
            end else begin
               fw_in = q13;
               fh_in = dh_ff;
            end
            state_in = FIT_OFS;
         end
         FIT_OFS: begin
            hx_in    = 12'((dw_ff - fw_ff) >> 1);
            hy_in    = 12'((dh_ff - fh_ff) >> 1);
            state_in = FIT_IDLE;
         end
         FIT_IDLE: begin
            state_in = FIT_IDLE;
         end
         default: begin
            state_in = FIT_LOAD;
         end
      endcase

      if (csr_we) begin
         state_in = FIT_LOAD;
         case (csr_index)
            CSR_SRC_WIDTH:   src_w_in = csr_wdata[12:0];
            CSR_SRC_HEIGHT:  src_h_in = csr_wdata[12:0];
            CSR_DISP_WIDTH:  dsp_w_in = csr_wdata[12:0];
            CSR_DISP_HEIGHT: dsp_h_in = csr_wdata[12:0];
            CSR_ROW_PITCH:   pitch_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign fit.ready = (state_ff == FIT_IDLE);
   assign fit.sw    = sw_ff;
   assign fit.sh    = sh_ff;
   assign fit.fw    = fw_ff;
   assign fit.fh    = fh_ff;
   assign fit.hx    = hx_ff;
   assign fit.hy    = hy_ff;
   assign fit.pitch = pitch_ff;
endmodule
`default_nettype wire

/* hw/rtl/nsf_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module nsf_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [12:0]            div_x,
   input  wire logic [12:0]            div_y,
   input  wire nsf_pkg::nsf_stage_type stage_in,
   output nsf_pkg::nsf_stage_type      stage_out
);
   import nsf_pkg::*;

   nsf_stage_type stage_ff, stage_in_c;
   logic [13:0] sh_x, sh_y;

   always_comb begin
      stage_in_c = stage_in;
      sh_x = {stage_in.rem_x, stage_in.dq_x[11]};
      sh_y = {stage_in.rem_y, stage_in.dq_y[11]};
      if (sh_x >= {1'b0, div_x}) begin
         stage_in_c.rem_x = 13'(sh_x - {1'b0, div_x});
         stage_in_c.dq_x  = {stage_in.dq_x[10:0], 1'b1};
      end else begin
         stage_in_c.rem_x = sh_x[12:0];
         stage_in_c.dq_x  = {stage_in.dq_x[10:0], 1'b0};
      end
      if (sh_y >= {1'b0, div_y}) begin
         stage_in_c.rem_y = 13'(sh_y - {1'b0, div_y});
         stage_in_c.dq_y  = {stage_in.dq_y[10:0], 1'b1};
      end else begin
         stage_in_c.rem_y = sh_y[12:0];
         stage_in_c.dq_y  = {stage_in.dq_y[10:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_c;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

/* hw/rtl/nearest_scale_fit_address_gen.sv */
`timescale 1ns / 1ps
`default_nettype none
// Fit-to-display nearest-neighbour address generator. One coordinate word is
// taken per clock while the chain advances and the fit is ready: one front stage
// forms the products and the display offset, then a chain of 12 divider
// cells each produces one quotient bit of src_x and src_y. A stalled result
// word holds the whole chain. After reset and after every csr write, a serial
// divider recomputes the fitted size, and req_ch.ready stays low until it
// has passed its load, multiply, select, divide, finish and offset states.
module nearest_scale_fit_address_gen (
   input  wire logic                             clock,
   input  wire logic                             reset,
   nsf_req_if.sink                               req_ch,
   nsf_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [nsf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [nsf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import nsf_pkg::*;

   nsf_fit_type   fit;
   nsf_stage_type stages [CELLS+1];
   nsf_stage_type front_in, front_ff;
   logic          advance;
   logic [24:0]   px, py;
   logic [11:0]   dx, dy;
   logic [25:0]   prod;

   nsf_fit u_fit (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .fit(fit)
   );

   assign advance      = !stages[CELLS].valid || rsp_ch.ready;
   assign req_ch.ready = advance && fit.ready;

   always_comb begin
      px   = {13'd0, req_ch.out_x} * {12'd0, fit.sw};
      py   = {13'd0, req_ch.out_y} * {12'd0, fit.sh};
      dx   = fit.hx + req_ch.out_x;
      dy   = fit.hy + req_ch.out_y;
      prod = {14'd0, dy} * {12'd0, fit.pitch};
      front_in.valid     = req_ch.valid && req_ch.ready;
      front_in.in_range  = ({1'b0, req_ch.out_x} < fit.fw) &&
                           ({1'b0, req_ch.out_y} < fit.fh);
      front_in.rem_x     = px[24:12];
      front_in.dq_x      = px[11:0];
      front_in.rem_y     = py[24:12];
      front_in.dq_y      = py[11:0];
      front_in.disp_x    = dx;
      front_in.disp_y    = dy;
      front_in.fb_offset = 25'(prod) + {13'd0, dx};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (advance) begin
         front_ff <= front_in;
      end
   end

   assign stages[0] = front_ff;

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      nsf_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .div_x(fit.fw), .div_y(fit.fh),
         .stage_in(stages[k]), .stage_out(stages[k+1])
      );
   end

   assign rsp_ch.valid      = stages[CELLS].valid;
   assign rsp_ch.in_range   = stages[CELLS].in_range;
   assign rsp_ch.src_x      = stages[CELLS].in_range ? stages[CELLS].dq_x : 12'd0;
   assign rsp_ch.src_y      = stages[CELLS].in_range ? stages[CELLS].dq_y : 12'd0;
   assign rsp_ch.disp_x     = stages[CELLS].in_range ? stages[CELLS].disp_x : 12'd0;
   assign rsp_ch.disp_y     = stages[CELLS].in_range ? stages[CELLS].disp_y : 12'd0;
   assign rsp_ch.fb_offset  = stages[CELLS].in_range ? stages[CELLS].fb_offset : 25'd0;
   assign rsp_ch.fit_width  = fit.fw;
   assign rsp_ch.fit_height = fit.fh;

`include "nearest_scale_fit_address_gen_assert.svh"

   `NSF_ASSERT_NEXT(a_write_stalls, clock, reset, csr_we, !req_ch.ready)
   `NSF_ASSERT_IMP(a_fit_nonzero, clock, reset, fit.ready,
      fit.fw != 13'd0 && fit.fh != 13'd0)
   `NSF_ASSERT_IMP(a_fit_bounded, clock, reset, fit.ready,
      fit.fw <= fit.sw || fit.fw == 13'd1)
endmodule
`default_nettype wire
